[rtl/etc_pkg.sv]
package etc_pkg;

   // Width of the incoming seconds count and the widths that follow from it
   localparam int SECONDS_WIDTH = 36;
   // 86400 > 2**16, so the day count always fits in SECONDS_WIDTH - 16 bits
   localparam int DAYS_WIDTH    = SECONDS_WIDTH - 16;
   // Shifted day count stays below 2**(DAYS_WIDTH + 5); 146097 > 2**17
   localparam int ERA_STEPS     = DAYS_WIDTH + 5 - 17;
   localparam int STEP_WIDTH    = $clog2(DAYS_WIDTH);

   localparam int YEAR_WIDTH    = 12;
   localparam int MONTH_WIDTH   = 4;
   localparam int MDAY_WIDTH    = 5;

   localparam logic [SECONDS_WIDTH-1:0] SECS_PER_DAY   = SECONDS_WIDTH'(86400);
   localparam logic [SECONDS_WIDTH-1:0] SECS_PER_HOUR  = SECONDS_WIDTH'(3600);
   localparam logic [SECONDS_WIDTH-1:0] SECS_PER_MIN   = SECONDS_WIDTH'(60);
   localparam logic [SECONDS_WIDTH-1:0] DAYS_PER_WEEK  = SECONDS_WIDTH'(7);
   localparam logic [SECONDS_WIDTH-1:0] DAYS_PER_ERA   = SECONDS_WIDTH'(146097);
   localparam logic [SECONDS_WIDTH-1:0] DAYS_PER_CENT  = SECONDS_WIDTH'(36524);
   localparam logic [SECONDS_WIDTH-1:0] DAYS_PER_QUAD  = SECONDS_WIDTH'(1461);
   localparam logic [SECONDS_WIDTH-1:0] DAYS_PER_YEAR  = SECONDS_WIDTH'(365);

   // Epoch day was a Thursday
   localparam logic [SECONDS_WIDTH-1:0] EPOCH_WEEKDAY  = SECONDS_WIDTH'(4);
   // Days from 0000-03-01 to 1970-01-01
   localparam logic [SECONDS_WIDTH-1:0] EPOCH_SHIFT    = SECONDS_WIDTH'(719468);
   // Year accumulator starts at -1900, modulo 2**YEAR_WIDTH
   localparam logic [YEAR_WIDTH-1:0]    YEAR_START     = YEAR_WIDTH'(4096 - 1900);

   localparam logic [YEAR_WIDTH-1:0]    YEARS_PER_ERA  = YEAR_WIDTH'(400);
   localparam logic [YEAR_WIDTH-1:0]    YEARS_PER_CENT = YEAR_WIDTH'(100);
   localparam logic [YEAR_WIDTH-1:0]    YEARS_PER_QUAD = YEAR_WIDTH'(4);
   localparam logic [YEAR_WIDTH-1:0]    YEARS_PER_YEAR = YEAR_WIDTH'(1);

   // Months counted from March: January and February are the last two
   localparam logic [MONTH_WIDTH-1:0]   MARCH_JAN_INDEX  = MONTH_WIDTH'(10);
   localparam logic [MONTH_WIDTH-1:0]   MARCH_LAST_INDEX = MONTH_WIDTH'(11);
   localparam logic [MONTH_WIDTH-1:0]   MARCH_OFFSET     = MONTH_WIDTH'(2);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_DAY,
      PH_HOUR,
      PH_MINUTE,
      PH_WEEK,
      PH_ERA,
      PH_CENT,
      PH_QUAD,
      PH_YEAR,
      PH_MONTH,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [SECONDS_WIDTH-1:0] acc;
      logic [SECONDS_WIDTH-1:0] divisor;
   } step_req_type;

   typedef struct packed {
      logic                     ge;
      logic [SECONDS_WIDTH-1:0] diff;
   } step_rsp_type;

   // Month lengths from March; February comes last and is never subtracted
   function automatic logic [SECONDS_WIDTH-1:0] march_month_len(
      input logic [MONTH_WIDTH-1:0] mp);
      logic [SECONDS_WIDTH-1:0] len;
      case (mp)
         4'd0:    len = SECONDS_WIDTH'(31);
         4'd1:    len = SECONDS_WIDTH'(30);
         4'd2:    len = SECONDS_WIDTH'(31);
         4'd3:    len = SECONDS_WIDTH'(30);
         4'd4:    len = SECONDS_WIDTH'(31);
         4'd5:    len = SECONDS_WIDTH'(31);
         4'd6:    len = SECONDS_WIDTH'(30);
         4'd7:    len = SECONDS_WIDTH'(31);
         4'd8:    len = SECONDS_WIDTH'(30);
         4'd9:    len = SECONDS_WIDTH'(31);
         4'd10:   len = SECONDS_WIDTH'(31);
         default: len = SECONDS_WIDTH'(29);
      endcase
      return len;
   endfunction

endpackage

[rtl/epoch_seconds_to_calendar_top.sv]
// Epoch seconds to UTC calendar converter.
//
// Input channel (req_): one word carries a count of seconds since
// 1970-01-01 00:00:00 UTC. The word is taken at a clock edge where
// req_valid is high and req_stall is low. req_stall is high while a
// conversion is in progress.
// Result channel (rsp_): one word with second, minute, hour, weekday
// (0 Sunday), year minus 1900, month from 0 and day of month from 1. It is
// held in an output register until taken (rsp_valid high, rsp_stall low).
//
// Sequencing: one shared compare/subtract unit runs a restoring division for
// each field: DAYS_WIDTH steps for days, 5 for hours, 6 for minutes,
// DAYS_WIDTH-2 for weekday, then 400/100/4/1 year chunks (ERA_STEPS+2+5+2)
// and 1..12 month steps, and then the output register is written.
// req_stall drops in the same cycle that rsp_valid rises, and a new word
// can be taken from then on.
// A stalled result does not block the next conversion; only the write of
// its result waits until the output register is free.
// Reset (synchronous) returns the sequencer to idle and drops any result.
module epoch_seconds_to_calendar_top
   import etc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [SECONDS_WIDTH-1:0] req_seconds_since_epoch,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [5:0]               rsp_second,
   output logic [5:0]               rsp_minute,
   output logic [4:0]               rsp_hour,
   output logic [2:0]               rsp_weekday,
   output logic [YEAR_WIDTH-1:0]    rsp_year_since_1900,
   output logic [MONTH_WIDTH-1:0]   rsp_month_index,
   output logic [MDAY_WIDTH-1:0]    rsp_day_of_month
);

   phase_type                phase_ff, phase_in;
   logic [STEP_WIDTH-1:0]    step_ff, step_in;
   logic [SECONDS_WIDTH-1:0] acc_ff, acc_in;
   logic [DAYS_WIDTH-1:0]    quo_ff, quo_in;
   logic [DAYS_WIDTH-1:0]    days_ff, days_in;
   logic [4:0]               hour_ff, hour_in;
   logic [5:0]               minute_ff, minute_in;
   logic [5:0]               second_ff, second_in;
   logic [2:0]               weekday_ff, weekday_in;
   logic [YEAR_WIDTH-1:0]    year_ff, year_in;
   logic [MONTH_WIDTH-1:0]   mp_ff, mp_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [5:0]               rsp_second_ff, rsp_minute_ff;
   logic [4:0]               rsp_hour_ff;
   logic [2:0]               rsp_weekday_ff;
   logic [YEAR_WIDTH-1:0]    rsp_year_ff;
   logic [MONTH_WIDTH-1:0]   rsp_month_ff;
   logic [MDAY_WIDTH-1:0]    rsp_mday_ff;

   logic                     load_out;
   logic [SECONDS_WIDTH-1:0] base;
   logic [YEAR_WIDTH-1:0]    weight;
   logic [DAYS_WIDTH-1:0]    quo_next;
   logic [SECONDS_WIDTH-1:0] acc_step;
   logic [YEAR_WIDTH-1:0]    year_step;
   logic                     last_step;
   logic                     out_free;

   step_req_type             step_req;
   step_rsp_type             step_rsp;

   etc_step_unit u_step (
      .req (step_req),
      .rsp (step_rsp)
   );

   // Pick the divisor and year weight for the current phase
   always_comb begin
      base   = DAYS_PER_YEAR;
      weight = '0;
      case (phase_ff)
         PH_DAY:    base = SECS_PER_DAY;
         PH_HOUR:   base = SECS_PER_HOUR;
         PH_MINUTE: base = SECS_PER_MIN;
         PH_WEEK:   base = DAYS_PER_WEEK;
         PH_ERA: begin
            base   = DAYS_PER_ERA;
            weight = YEARS_PER_ERA;
         end
         PH_CENT: begin
            base   = DAYS_PER_CENT;
            weight = YEARS_PER_CENT;
         end
         PH_QUAD: begin
            base   = DAYS_PER_QUAD;
            weight = YEARS_PER_QUAD;
         end
         PH_YEAR: begin
            base   = DAYS_PER_YEAR;
            weight = YEARS_PER_YEAR;
         end
         default: ;
      endcase
   end

   assign step_req.acc     = acc_ff;
   assign step_req.divisor = (phase_ff == PH_MONTH) ? march_month_len(mp_ff)
                                                    : (base << step_ff);

   assign quo_next  = {quo_ff[DAYS_WIDTH-2:0], step_rsp.ge};
   assign acc_step  = step_rsp.ge ? step_rsp.diff : acc_ff;
   assign year_step = step_rsp.ge ? (year_ff + (weight << step_ff)) : year_ff;
   assign last_step = (step_ff == '0);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Sequencer: next state and working registers
   always_comb begin
      phase_in   = phase_ff;
      step_in    = step_ff;
      acc_in     = acc_ff;
      quo_in     = quo_ff;
      days_in    = days_ff;
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      second_in  = second_ff;
      weekday_in = weekday_ff;
      year_in    = year_ff;
      mp_in      = mp_ff;
      load_out   = 1'b0;

      if (!(phase_ff inside {PH_IDLE, PH_MONTH, PH_DONE})) begin
         acc_in  = acc_step;
         quo_in  = quo_next;
         step_in = step_ff - 1'b1;
      end

      case (phase_ff)
         PH_IDLE: begin
            if (req_valid) begin
               acc_in   = req_seconds_since_epoch;
               step_in  = STEP_WIDTH'(DAYS_WIDTH - 1);
               phase_in = PH_DAY;
            end
         end
         PH_DAY: begin
            if (last_step) begin
               days_in  = quo_next;
               step_in  = STEP_WIDTH'(4);
               phase_in = PH_HOUR;
            end
         end
         PH_HOUR: begin
            if (last_step) begin
               hour_in  = quo_next[4:0];
               step_in  = STEP_WIDTH'(5);
               phase_in = PH_MINUTE;
            end
         end
         PH_MINUTE: begin
            if (last_step) begin
               minute_in = quo_next[5:0];
               second_in = acc_step[5:0];
               acc_in    = SECONDS_WIDTH'(days_ff) + EPOCH_WEEKDAY;
               step_in   = STEP_WIDTH'(DAYS_WIDTH - 3);
               phase_in  = PH_WEEK;
            end
         end
         PH_WEEK: begin
            if (last_step) begin
               weekday_in = acc_step[2:0];
               acc_in     = SECONDS_WIDTH'(days_ff) + EPOCH_SHIFT;
               year_in    = YEAR_START;
               step_in    = STEP_WIDTH'(ERA_STEPS - 1);
               phase_in   = PH_ERA;
            end
         end
         PH_ERA: begin
            year_in = year_step;
            if (last_step) begin
               step_in  = STEP_WIDTH'(1);
               phase_in = PH_CENT;
            end
         end
         PH_CENT: begin
            year_in = year_step;
            if (last_step) begin
               step_in  = STEP_WIDTH'(4);
               phase_in = PH_QUAD;
            end
         end
         PH_QUAD: begin
            year_in = year_step;
            if (last_step) begin
               step_in  = STEP_WIDTH'(1);
               phase_in = PH_YEAR;
            end
         end
         PH_YEAR: begin
            year_in = year_step;
            if (last_step) begin
               mp_in    = '0;
               phase_in = PH_MONTH;
            end
         end
         PH_MONTH: begin
            // Advance one month while the remaining days cover it
            if (step_rsp.ge && mp_ff < MARCH_LAST_INDEX) begin
               acc_in = step_rsp.diff;
               mp_in  = mp_ff + 1'b1;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_DONE: begin
            // Hold until the output register can take the word
            if (out_free) begin
               load_out = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      acc_ff     <= acc_in;
      quo_ff     <= quo_in;
      days_ff    <= days_in;
      hour_ff    <= hour_in;
      minute_ff  <= minute_in;
      second_ff  <= second_in;
      weekday_ff <= weekday_in;
      year_ff    <= year_in;
      mp_ff      <= mp_in;
   end

   // Result word; January and February close the March-based year
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_second_ff  <= second_ff;
         rsp_minute_ff  <= minute_ff;
         rsp_hour_ff    <= hour_ff;
         rsp_weekday_ff <= weekday_ff;
         rsp_year_ff    <= year_ff + YEAR_WIDTH'(mp_ff >= MARCH_JAN_INDEX);
         rsp_month_ff   <= (mp_ff < MARCH_JAN_INDEX) ? (mp_ff + MARCH_OFFSET)
                                                     : (mp_ff - MARCH_JAN_INDEX);
         rsp_mday_ff    <= acc_ff[MDAY_WIDTH-1:0] + 1'b1;
      end
   end

   assign req_stall           = (phase_ff != PH_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_second          = rsp_second_ff;
   assign rsp_minute          = rsp_minute_ff;
   assign rsp_hour            = rsp_hour_ff;
   assign rsp_weekday         = rsp_weekday_ff;
   assign rsp_year_since_1900 = rsp_year_ff;
   assign rsp_month_index     = rsp_month_ff;
   assign rsp_day_of_month    = rsp_mday_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (phase_ff == PH_DAY))
      else $error("accepted word did not start the day division");

   a_month_days: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_MONTH) |-> (acc_ff < SECONDS_WIDTH'(366) && mp_ff <= MARCH_LAST_INDEX))
      else $error("day of year out of range in month stepping");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hour < 5'd24 && rsp_minute < 6'd60 && rsp_second < 6'd60))
      else $error("time of day out of range");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_weekday < 3'd7 && rsp_month_index <= MARCH_LAST_INDEX
                     && rsp_day_of_month != '0))
      else $error("date field out of range");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE && rsp_valid && rsp_stall) |=> (phase_ff == PH_DONE))
      else $error("result written over a stalled word");

endmodule

[rtl/etc_step_unit.sv]
module etc_step_unit
   import etc_pkg::*;
(
   input  step_req_type req,
   output step_rsp_type rsp
);

   // One restoring-division step: compare, and the difference to keep on success
   assign rsp.ge   = (req.acc >= req.divisor);
   assign rsp.diff = req.acc - req.divisor;

endmodule
